@@ rtl/clwu_pkg.sv @@
// Package for the countdown latch wake unit: field widths, register map,
// command, status and sequencer state codes. Depends on nothing.
package clwu_pkg;

	// Fixed field widths of the channels and the configuration port
	localparam int COUNT_W    = 16;
	localparam int ID_W       = 8;
	localparam int STATUS_W   = 3;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register index, taken from paddr[2]
	localparam logic REG_INITIAL_COUNT = 1'b0;

	typedef enum logic {
		CMD_WAIT   = 1'b0,
		CMD_SIGNAL = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PROCEED = 3'd0,
		ST_QUEUED  = 3'd1,
		ST_FULL    = 3'd2,
		ST_COUNTED = 3'd3,
		ST_WAKE    = 3'd4,
		ST_ZERO    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_CHECK,
		S_FILL,
		S_RD,
		S_OUT
	} state_t;

endpackage

@@ rtl/clwu_if.sv @@
// Channel interfaces of the countdown latch wake unit: request and result.
// Depends on clwu_pkg for field widths.
interface clwu_req_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [clwu_pkg::ID_W-1:0]   thread_id;

	modport source (output valid, command, thread_id, input ready);
	modport sink   (input valid, command, thread_id, output ready);
endinterface

interface clwu_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [clwu_pkg::STATUS_W-1:0] status;
	logic [clwu_pkg::ID_W-1:0]     wake_id;
	logic                          last;

	modport source (output valid, status, wake_id, last, input ready);
	modport sink   (input valid, status, wake_id, last, output ready);
endinterface

@@ rtl/countdown_latch_wake_unit_top.sv @@
// Countdown latch wake unit: count register, waiter queue memory and a
// sequencer around one shared increment/decrement unit.
// Depends on clwu_pkg and the interfaces in clwu_if.sv.
//
// Usage:
//   req (valid/ready) carries one command per transfer: a wait request with
//   the caller's thread_id, or a signal that counts the latch down.
//   rsp (valid/ready) returns the results; last marks the final result of a
//   request. A wait returns proceed, queued or queue full; a signal returns
//   counted or already zero, or, when it brings the count to zero with
//   waiters present, one wake per queued id in arrival order.
//   The APB port holds initial_count at address 0; writing it reloads the
//   count and empties the queue. Write it only while the unit is idle.
// Timing:
//   Proceed, queue full and already zero go from S_DECIDE straight to S_OUT,
//   which loads the result register; queued passes through S_FILL and counted
//   through S_CHECK first. req is ready again in the cycle after the result
//   register loads. Each wake of a drain takes S_RD (queue memory read) and
//   then S_OUT (result load). When rsp stalls, the pending result holds in
//   the output register and the sequencer waits; no result is dropped.
//   Reset clears the count, the queue pointers and the fill level; queue
//   memory contents need no reset.
module countdown_latch_wake_unit_top #(
	parameter int QUEUE_DEPTH = 32,
	parameter int ID_BITS     = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	clwu_req_if.sink                          req,
	clwu_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [clwu_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [clwu_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [clwu_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int CW     = clwu_pkg::COUNT_W;
	localparam int IW     = clwu_pkg::ID_W;
	localparam int DW     = clwu_pkg::APB_DATA_W;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int XW     = (ID_BITS > IW) ? ID_BITS : IW;

	// Registers
	clwu_pkg::state_t  state_q, nxt_state;
	logic [CW-1:0]     init_count_q;
	logic [CW-1:0]     remaining_q;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [FILL_W-1:0] fill_q;
	logic              drain_q;
	logic              rsp_valid_q;
	logic              cmd_q;
	logic [ID_BITS-1:0] tid_q;
	logic [ID_BITS-1:0] rd_q;
	clwu_pkg::status_t res_status_q;
	logic              res_last_q;
	logic [clwu_pkg::STATUS_W-1:0] out_status_q;
	logic [IW-1:0]     out_wake_id_q;
	logic              out_last_q;
	logic [ID_BITS-1:0] queue_mem [QUEUE_DEPTH];

	// Sequencer controls
	logic              ld_in, mem_wr, mem_rd, tail_adv, head_adv;
	logic              rem_wr, fill_wr, res_ld, out_ld, q_clear, drain_set;
	logic              alu_sel_fill, alu_sub;
	clwu_pkg::status_t res_status_d;
	logic              res_last_d;

	// Datapath
	logic [CW-1:0]     alu_a, alu_y;
	logic              rem_zero, q_full, q_empty, cfg_wr;
	logic [XW-1:0]     tid_wide, rd_wide;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == clwu_pkg::REG_INITIAL_COUNT);
	assign prdata   = (paddr[2] == clwu_pkg::REG_INITIAL_COUNT) ? DW'(init_count_q) : '0;

	assign rem_zero = (remaining_q == '0);
	assign q_full   = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign q_empty  = (fill_q == '0);
	assign tid_wide = XW'(req.thread_id);
	assign rd_wide  = XW'(rd_q);

	// Shared increment/decrement unit for the count and the fill level
	assign alu_a = alu_sel_fill ? CW'(fill_q) : remaining_q;
	assign alu_y = alu_sub ? alu_a - 1'b1 : alu_a + 1'b1;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clwu_pkg::S_IDLE;
		end else begin
			state_q <= nxt_state;
		end
	end

	// Next state and sequencer controls
	always_comb begin
		nxt_state    = state_q;
		req.ready    = 1'b0;
		ld_in        = 1'b0;
		mem_wr       = 1'b0;
		mem_rd       = 1'b0;
		tail_adv     = 1'b0;
		head_adv     = 1'b0;
		rem_wr       = 1'b0;
		fill_wr      = 1'b0;
		res_ld       = 1'b0;
		out_ld       = 1'b0;
		q_clear      = 1'b0;
		drain_set    = 1'b0;
		alu_sel_fill = 1'b0;
		alu_sub      = 1'b1;
		res_status_d = clwu_pkg::ST_COUNTED;
		res_last_d   = 1'b1;
		case (state_q)
			clwu_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					ld_in     = 1'b1;
					nxt_state = clwu_pkg::S_DECIDE;
				end
			end
			clwu_pkg::S_DECIDE: begin
				if (cmd_q == clwu_pkg::CMD_WAIT) begin
					if (rem_zero) begin
						res_ld       = 1'b1;
						res_status_d = clwu_pkg::ST_PROCEED;
						nxt_state    = clwu_pkg::S_OUT;
					end else if (q_full) begin
						res_ld       = 1'b1;
						res_status_d = clwu_pkg::ST_FULL;
						nxt_state    = clwu_pkg::S_OUT;
					end else begin
						mem_wr    = 1'b1;
						tail_adv  = 1'b1;
						nxt_state = clwu_pkg::S_FILL;
					end
				end else begin
					if (rem_zero) begin
						res_ld       = 1'b1;
						res_status_d = clwu_pkg::ST_ZERO;
						nxt_state    = clwu_pkg::S_OUT;
					end else begin
						rem_wr    = 1'b1;
						nxt_state = clwu_pkg::S_CHECK;
					end
				end
			end
			clwu_pkg::S_CHECK: begin
				// Count already decremented: drain only at zero with waiters
				if (!rem_zero || q_empty) begin
					res_ld       = 1'b1;
					res_status_d = clwu_pkg::ST_COUNTED;
					nxt_state    = clwu_pkg::S_OUT;
				end else begin
					drain_set = 1'b1;
					nxt_state = clwu_pkg::S_RD;
				end
			end
			clwu_pkg::S_FILL: begin
				alu_sel_fill = 1'b1;
				alu_sub      = 1'b0;
				fill_wr      = 1'b1;
				res_ld       = 1'b1;
				res_status_d = clwu_pkg::ST_QUEUED;
				nxt_state    = clwu_pkg::S_OUT;
			end
			clwu_pkg::S_RD: begin
				mem_rd       = 1'b1;
				head_adv     = 1'b1;
				alu_sel_fill = 1'b1;
				fill_wr      = 1'b1;
				res_ld       = 1'b1;
				res_status_d = clwu_pkg::ST_WAKE;
				res_last_d   = (alu_y[FILL_W-1:0] == '0);
				nxt_state    = clwu_pkg::S_OUT;
			end
			clwu_pkg::S_OUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_ld = 1'b1;
					if (drain_q && !q_empty) begin
						nxt_state = clwu_pkg::S_RD;
					end else begin
						q_clear   = drain_q;
						nxt_state = clwu_pkg::S_IDLE;
					end
				end
			end
			default: begin
				nxt_state = clwu_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers: count, queue pointers, fill level, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_count_q <= '0;
			remaining_q  <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			drain_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				init_count_q <= pwdata[CW-1:0];
				remaining_q  <= pwdata[CW-1:0];
				head_q       <= '0;
				tail_q       <= '0;
				fill_q       <= '0;
			end else begin
				if (rem_wr) begin
					remaining_q <= alu_y;
				end
				if (fill_wr) begin
					fill_q <= alu_y[FILL_W-1:0];
				end
				if (tail_adv) begin
					tail_q <= next_slot(tail_q);
				end
				if (head_adv) begin
					head_q <= next_slot(head_q);
				end
				if (q_clear) begin
					head_q <= '0;
					tail_q <= '0;
				end
			end
			if (drain_set) begin
				drain_q <= 1'b1;
			end else if (q_clear) begin
				drain_q <= 1'b0;
			end
			if (out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: captured request, pending result, output register
	always_ff @(posedge clk) begin
		if (ld_in) begin
			cmd_q <= req.command;
			tid_q <= tid_wide[ID_BITS-1:0];
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_last_q   <= res_last_d;
		end
		if (out_ld) begin
			out_status_q  <= res_status_q;
			out_last_q    <= res_last_q;
			out_wake_id_q <= (res_status_q == clwu_pkg::ST_WAKE) ? rd_wide[IW-1:0] : '0;
		end
	end

	// Waiter queue memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			queue_mem[tail_q] <= tid_q;
		end
		if (mem_rd) begin
			rd_q <= queue_mem[head_q];
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.wake_id = out_wake_id_q;
	assign rsp.last    = out_last_q;

endmodule

@@ rtl/clwu_chk.sv @@
// Port checker for the countdown latch wake unit, bound to the top level.
// Depends on clwu_pkg for status codes.
module clwu_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [clwu_pkg::STATUS_W-1:0] rsp_status,
	input logic [clwu_pkg::ID_W-1:0]     rsp_wake_id,
	input logic                          rsp_last
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_wake_id) && $stable(rsp_last))
		else $error("stalled result changed");

	// One request at a time: no transfer in the cycle after a transfer
	a_req_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Only a wake carries an id
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != clwu_pkg::ST_WAKE) |-> rsp_wake_id == '0)
		else $error("id on a result that is not a wake");

	// Every result other than a wake closes its request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != clwu_pkg::ST_WAKE) |-> rsp_last)
		else $error("single result without last");

endmodule

bind countdown_latch_wake_unit_top clwu_chk u_clwu_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_wake_id (rsp.wake_id),
	.rsp_last    (rsp.last)
);

@@ tb/clwu_latch_check_pkg.sv @@
// Checking side of the countdown latch testbench: a predictor of the count,
// the waiter queue and the store of results still due. Depends on clwu_pkg.
package clwu_latch_check_pkg;
	import clwu_pkg::*;

	localparam int WAITER_SLOTS = 32;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     wake_id;
		logic                last;
	} latch_result_t;

	class latch_tracker;
		logic [COUNT_W-1:0] count_reg = '0;
		logic [COUNT_W-1:0] remaining = '0;
		logic [ID_W-1:0]    waiters[$];
		latch_result_t      due_results[$];
		int                 mismatches = 0;

		// Reload the count and drop every waiter, as a register write does
		function void load_count(logic [COUNT_W-1:0] value);
			count_reg = value;
			remaining = value;
			waiters.delete();
		endfunction

		function void push_result(status_t st, logic [ID_W-1:0] id, logic fin);
			latch_result_t r;
			r.status  = st;
			r.wake_id = id;
			r.last    = fin;
			due_results.push_back(r);
		endfunction

		// Work out the results of one request transfer
		function void accept_request(cmd_t cmd, logic [ID_W-1:0] tid);
			logic [ID_W-1:0] id;
			if (cmd == CMD_WAIT) begin
				if (remaining == 0)
					push_result(ST_PROCEED, '0, 1'b1);
				else if (waiters.size() >= WAITER_SLOTS)
					push_result(ST_FULL, '0, 1'b1);
				else begin
					waiters.push_back(tid);
					push_result(ST_QUEUED, '0, 1'b1);
				end
			end else if (remaining == 0) begin
				push_result(ST_ZERO, '0, 1'b1);
			end else begin
				remaining = remaining - 1'b1;
				if (remaining != 0 || waiters.size() == 0) begin
					push_result(ST_COUNTED, '0, 1'b1);
				end else begin
					// Release every waiter in arrival order, mark the final one
					while (waiters.size() > 0) begin
						id = waiters.pop_front();
						push_result(ST_WAKE, id, waiters.size() == 0);
					end
				end
			end
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id, logic fin);
			latch_result_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result: status %0d wake_id %02h last %0b",
						$realtime, st, id, fin);
				return;
			end
			want = due_results.pop_front();
			if (st !== want.status || id !== want.wake_id || fin !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result mismatch: status exp %0d got %0d, wake_id exp %02h got %02h, last exp %0b got %0b",
						$realtime, want.status, st, want.wake_id, id, want.last, fin);
			end
		endfunction

		// Compare a register read with the last value written
		function void check_readback(logic [APB_DATA_W-1:0] got);
			logic [APB_DATA_W-1:0] want;
			want = {{(APB_DATA_W - COUNT_W){1'b0}}, count_reg};
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: initial_count read mismatch: exp %08h got %08h",
						$realtime, want, got);
			end
		endfunction
	endclass

endpackage

@@ tb/tb_countdown_latch_wake_unit_top.sv @@
// Testbench top for the countdown latch wake unit: drives request transfers,
// APB register writes and result back-pressure, and checks every result.
// Depends on clwu_pkg, clwu_if.sv, clwu_latch_check_pkg and the RTL top.
module tb_countdown_latch_wake_unit_top;
	timeunit 1ns;
	timeprecision 1ps;

	import clwu_pkg::*;
	import clwu_latch_check_pkg::*;

	localparam logic REG_UNMAPPED   = 1'b1;
	localparam int   RANDOM_ITEMS   = 300;
	localparam int   SETTLE_CYCLES  = 16;
	localparam int   DRAIN_LIMIT    = 20000;
	localparam int   HOLDOFF_ROUND  = 4;
	localparam int   HOLDOFF_CYCLES = 300;
	localparam real  RUN_LIMIT_NS   = 5.0e6;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int rsp_holdoff   = 0;

	latch_tracker tracker = new;

	clwu_req_if req_ch ();
	clwu_rsp_if rsp_ch ();

	countdown_latch_wake_unit_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check each result transfer
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			tracker.check_result(rsp_ch.status, rsp_ch.wake_id, rsp_ch.last);
	end

	// Stall the result side at random, or hold it off for a long stretch
	always @(negedge clk) begin
		if (rsp_holdoff > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_holdoff = rsp_holdoff - 1;
		end else
			rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
	end

	// Offer one request, idling first at random; return at the next falling edge
	task automatic send_request(input cmd_t cmd, input logic [ID_W-1:0] tid);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.command   <= cmd;
		req_ch.thread_id <= tid;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		tracker.accept_request(cmd, tid);
		@(negedge clk);
	endtask

	// Run one APB setup and access phase, then return to idle
	task automatic apb_transfer(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data, output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has arrived
	task automatic settle();
		int waited;
		waited = 0;
		req_ch.valid <= 1'b0;
		while (tracker.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write initial_count while idle and read it back
	task automatic reload_count(input logic [COUNT_W-1:0] value);
		logic [APB_DATA_W-1:0] rd;
		settle();
		apb_transfer(1'b1, {REG_INITIAL_COUNT, 2'b00}, {{(APB_DATA_W - COUNT_W){1'b0}}, value},
			rd);
		tracker.load_count(value);
		apb_transfer(1'b0, {REG_INITIAL_COUNT, 2'b00}, '0, rd);
		tracker.check_readback(rd);
	endtask

	// One latch cycle: load a count, queue waiters among the signals, open the latch
	task automatic run_round(input int round, inout int sent);
		int                 n_wait;
		int                 n_sig;
		int                 pick;
		logic [COUNT_W-1:0] start_count;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			start_count = '1;
		else if (pick == 1)
			start_count = '0;
		else
			start_count = COUNT_W'($urandom_range(1, 4));
		if (round == HOLDOFF_ROUND)
			start_count = 16'd2;
		if (round == HOLDOFF_ROUND || round == 2 || $urandom_range(0, 7) == 0)
			n_wait = $urandom_range(30, 36);
		else
			n_wait = $urandom_range(0, 8);
		reload_count(start_count);

		// Rotate through the idling modes
		case (round % 4)
			0: begin
				send_idle_pct = 0;
				rsp_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 50;
				rsp_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				rsp_stall_pct = 50;
			end
			default: begin
				send_idle_pct = 9;
				rsp_stall_pct = 9;
			end
		endcase
		if (round == HOLDOFF_ROUND)
			rsp_holdoff = HOLDOFF_CYCLES;

		// Mix the waits with all signals but the one that opens the latch; for the largest count, with two signals only
		if (start_count == 0)
			n_sig = 0;
		else if (start_count == '1)
			n_sig = 2;
		else
			n_sig = start_count - 1;
		while (n_wait + n_sig > 0) begin
			if (n_sig == 0 || (n_wait > 0 && $urandom_range(1, n_wait + n_sig) <= n_wait)) begin
				send_request(CMD_WAIT, ID_W'($urandom()));
				n_wait--;
			end else begin
				send_request(CMD_SIGNAL, ID_W'($urandom()));
				n_sig--;
			end
			sent++;
		end

		// Open the latch, now and then leave the sequence broken
		if (start_count != 0 && start_count != '1 && $urandom_range(0, 5) != 0) begin
			send_request(CMD_SIGNAL, ID_W'($urandom()));
			sent++;
		end

		// Add stray commands
		repeat ($urandom_range(0, 2))
			send_request(cmd_t'($urandom_range(0, 1)), ID_W'($urandom()));
	endtask

	initial begin
		logic [APB_DATA_W-1:0] rd;
		int                    sent;
		int                    round;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.command   = CMD_WAIT;
		req_ch.thread_id = '0;
		rsp_ch.ready     = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Latch open after reset: wait proceeds, signal returns already zero
		send_request(CMD_WAIT, 8'h00);
		send_request(CMD_SIGNAL, 8'hFF);

		// Queue three waiters, count down, release them in order
		reload_count(16'd3);
		send_request(CMD_WAIT, 8'hFF);
		send_request(CMD_WAIT, 8'h00);
		send_request(CMD_WAIT, 8'h5A);
		repeat (3) send_request(CMD_SIGNAL, 8'h00);
		send_request(CMD_SIGNAL, 8'hA5);
		send_request(CMD_WAIT, 8'h3C);

		// Write an unmapped register; the count stays as it was
		settle();
		apb_transfer(1'b1, {REG_UNMAPPED, 2'b00}, 32'd7, rd);
		apb_transfer(1'b0, {REG_INITIAL_COUNT, 2'b00}, '0, rd);
		tracker.check_readback(rd);
		send_request(CMD_WAIT, 8'hC3);

		// Reach zero with nobody waiting
		reload_count(16'd1);
		send_request(CMD_SIGNAL, 8'h18);

		// Largest count, then clear it while a waiter is queued
		reload_count(16'hFFFF);
		send_request(CMD_WAIT, 8'h81);
		send_request(CMD_SIGNAL, 8'h00);
		reload_count(16'h0000);
		send_request(CMD_SIGNAL, 8'h00);
		send_request(CMD_WAIT, 8'h7E);

		// Waits between signals
		reload_count(16'd2);
		send_request(CMD_WAIT, 8'h01);
		send_request(CMD_SIGNAL, 8'h00);
		send_request(CMD_WAIT, 8'h80);
		send_request(CMD_SIGNAL, 8'h00);

		// Random latch cycles
		sent  = 0;
		round = 0;
		while (sent < RANDOM_ITEMS) begin
			run_round(round, sent);
			round++;
		end

		settle();
		if (tracker.due_results.size() != 0)
			$display("%0d expected results never arrived", tracker.due_results.size());
		if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/clwu_pkg.sv
rtl/clwu_if.sv
rtl/countdown_latch_wake_unit_top.sv
rtl/clwu_chk.sv
tb/clwu_latch_check_pkg.sv
tb/tb_countdown_latch_wake_unit_top.sv
